@@ rtl/drxc_pkg.sv @@
// ----------------------------------------------------------------------------
// drxc_pkg
// Shared types and constants of the DRX sleep-cycle controller: payload
// words, configuration set, timer state, controller states and commands.
// ----------------------------------------------------------------------------
package drxc_pkg;

  // field widths
  localparam int SLOT_BITS  = 18;
  localparam int TIMER_BITS = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // count value that marks an expired timer
  localparam logic [TIMER_BITS-1:0] TMR_EXPIRED = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRX_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_CYCLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_CYCLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_DUR_LEN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INACT_LEN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TMR    = 3'd7;

  // configuration reset values
  localparam logic [17:0] CFG_RST_LONG_CYCLE  = 18'd160;
  localparam logic [17:0] CFG_RST_SHORT_CYCLE = 18'd40;
  localparam logic [17:0] CFG_RST_LONG_OFFSET = 18'd0;
  localparam logic [14:0] CFG_RST_ON_DUR_LEN  = 15'd16;
  localparam logic [15:0] CFG_RST_INACT_LEN   = 16'd16;
  localparam logic [17:0] CFG_RST_SHORT_TMR   = 18'd160;

  // short offset that follows from the reset configuration
  localparam int RST_SHORT_OFFSET_INT =
    (CFG_RST_LONG_OFFSET % CFG_RST_LONG_CYCLE) % CFG_RST_SHORT_CYCLE;
  localparam logic [SLOT_BITS-1:0] RST_SHORT_OFFSET = SLOT_BITS'(RST_SHORT_OFFSET_INT);

  // input word
  typedef struct packed {
    logic [17:0] slot_number;
    logic        new_pdcch;
    logic        restart;
  } drxc_in_t;

  // result word
  typedef struct packed {
    logic awake;
    logic short_mode;
    logic on_duration_running;
    logic inactivity_running;
  } drxc_out_t;

  // configuration set
  typedef struct packed {
    logic        drx_enable;
    logic        short_enable;
    logic [17:0] long_cycle;
    logic [17:0] short_cycle;
    logic [17:0] long_offset;
    logic [14:0] on_duration_len;
    logic [15:0] inactivity_len;
    logic [17:0] short_timer_len;
  } drxc_cfg_t;

  // countdown timer with start delay
  typedef struct packed {
    logic [TIMER_BITS-1:0] cnt;
    logic [SLOT_BITS-1:0]  dly;
    logic                  act;
  } drxc_tmr_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_STEP1,
    ST_STEP2
  } drxc_state_e;

  // remainder jobs of one slot
  typedef enum logic [1:0] {
    OP_LOFF,
    OP_SLOT_LONG,
    OP_SLOT_SHORT,
    OP_LOFF_SHORT
  } drxc_op_e;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     div_start;
    logic     rem_load;
    drxc_op_e op;
    logic     step1;
    logic     step2;
  } drxc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
    logic restart;
  } drxc_status_t;

endpackage

@@ rtl/drx_sleep_cycle_controller.sv @@
// ----------------------------------------------------------------------------
// drx_sleep_cycle_controller
// Each slot word runs three remainder jobs on the shared remainder unit,
// four for a restart word, then two timer update steps; one word is taken
// at a time, and a result still waiting holds the next word in step two.
// The result register frees the input side while a result waits.
// Reset: asynchronous, active low; control, configuration and timer registers
// take reset values: timers cleared and off, receiver awake, long cycle mode.
// ----------------------------------------------------------------------------
module drx_sleep_cycle_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  drxc_pkg::drxc_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output drxc_pkg::drxc_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [drxc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [drxc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import drxc_pkg::*;

  drxc_cfg_t    cfg;
  drxc_cmd_t    cmd;
  drxc_status_t status;

  // configuration registers
  drxc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // slot sequencer
  drxc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // timers and result
  drxc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/drxc_cfg.sv @@
// ----------------------------------------------------------------------------
// drxc_cfg
// Configuration register file, one write port, all registers always visible.
// ----------------------------------------------------------------------------
module drxc_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [drxc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [drxc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output drxc_pkg::drxc_cfg_t                cfg_o
);
  import drxc_pkg::*;

  drxc_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drx_enable      <= 1'b0;
      cfg_q.short_enable    <= 1'b0;
      cfg_q.long_cycle      <= CFG_RST_LONG_CYCLE;
      cfg_q.short_cycle     <= CFG_RST_SHORT_CYCLE;
      cfg_q.long_offset     <= CFG_RST_LONG_OFFSET;
      cfg_q.on_duration_len <= CFG_RST_ON_DUR_LEN;
      cfg_q.inactivity_len  <= CFG_RST_INACT_LEN;
      cfg_q.short_timer_len <= CFG_RST_SHORT_TMR;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DRX_ENABLE:   cfg_q.drx_enable      <= cfg_data_i[0];
        CFG_SHORT_ENABLE: cfg_q.short_enable    <= cfg_data_i[0];
        CFG_LONG_CYCLE:   cfg_q.long_cycle      <= cfg_data_i[17:0];
        CFG_SHORT_CYCLE:  cfg_q.short_cycle     <= cfg_data_i[17:0];
        CFG_LONG_OFFSET:  cfg_q.long_offset     <= cfg_data_i[17:0];
        CFG_ON_DUR_LEN:   cfg_q.on_duration_len <= cfg_data_i[14:0];
        CFG_INACT_LEN:    cfg_q.inactivity_len  <= cfg_data_i[15:0];
        CFG_SHORT_TMR:    cfg_q.short_timer_len <= cfg_data_i[17:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/drxc_ctrl.sv @@
// ----------------------------------------------------------------------------
// drxc_ctrl
// Slot sequencer: captures a word, runs the remainder jobs on the shared
// divider, then the two timer update steps and the result hand-off.
// ----------------------------------------------------------------------------
module drxc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  drxc_pkg::drxc_status_t status_i,
  output drxc_pkg::drxc_cmd_t    cmd_o
);
  import drxc_pkg::*;

  drxc_state_e state_q, state_d;
  drxc_op_e    op_q, op_d;
  logic        last_op;

  // the short-offset job only runs for a restart word
  assign last_op = (op_q == OP_LOFF_SHORT) ||
                   ((op_q == OP_SLOT_SHORT) && !status_i.restart);

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIV_START;
          op_d    = OP_LOFF;
        end
      end
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          if (last_op) begin
            state_d = ST_STEP1;
          end else begin
            state_d = ST_DIV_START;
            case (op_q)
              OP_LOFF:       op_d = OP_SLOT_LONG;
              OP_SLOT_LONG:  op_d = OP_SLOT_SHORT;
              OP_SLOT_SHORT: op_d = OP_LOFF_SHORT;
              default:       op_d = OP_LOFF_SHORT;
            endcase
          end
        end
      end
      ST_STEP1: state_d = ST_STEP2;
      ST_STEP2: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = op_q;
    cmd_o.capture   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_start = (state_q == ST_DIV_START);
    cmd_o.rem_load  = (state_q == ST_DIV_WAIT) && status_i.div_done;
    cmd_o.step1     = (state_q == ST_STEP1);
    cmd_o.step2     = (state_q == ST_STEP2) && status_i.out_free;
    in_ready_o      = (state_q == ST_IDLE);
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_LOFF;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

@@ rtl/drxc_div.sv @@
// ----------------------------------------------------------------------------
// drxc_div
// Restoring remainder unit, two quotient bits per cycle. The divisor must
// be nonzero; the remainder is held until the next start.
// ----------------------------------------------------------------------------
module drxc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [drxc_pkg::SLOT_BITS-1:0] dividend_i,
  input  logic [drxc_pkg::SLOT_BITS-1:0] divisor_i,
  output logic                           done_o,
  output logic [drxc_pkg::SLOT_BITS-1:0] rem_o
);
  import drxc_pkg::*;

  localparam int Steps = (SLOT_BITS + 1) / 2;
  localparam int AW    = 2 * Steps;
  localparam int CntW  = $clog2(Steps);
  localparam logic [CntW-1:0] CntLast = CntW'(Steps - 1);

  logic                 busy_q, done_q;
  logic [CntW-1:0]      cnt_q;
  logic [AW-1:0]        a_q;
  logic [SLOT_BITS-1:0] r_q, d_q;
  logic [SLOT_BITS:0]   r1, r2;
  logic [SLOT_BITS-1:0] r_d;

  assign done_o = done_q;
  assign rem_o  = r_q;

  // two compare-subtract stages per cycle
  always_comb begin
    r1 = {r_q, a_q[AW-1]};
    if (r1 >= {1'b0, d_q}) begin
      r1 = r1 - {1'b0, d_q};
    end
    r2 = {r1[SLOT_BITS-1:0], a_q[AW-2]};
    if (r2 >= {1'b0, d_q}) begin
      r2 = r2 - {1'b0, d_q};
    end
    r_d = r2[SLOT_BITS-1:0];
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // operand and remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= AW'(dividend_i);
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      a_q <= {a_q[AW-3:0], 2'b00};
      r_q <= r_d;
    end
  end

endmodule

@@ rtl/drxc_dp.sv @@
// ----------------------------------------------------------------------------
// drxc_dp
// Datapath: captured slot word, remainders, the three DRX timers, cycle
// mode, awake flag and the result register.
// ----------------------------------------------------------------------------
module drxc_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  drxc_pkg::drxc_in_t     in_data_i,
  input  drxc_pkg::drxc_cfg_t    cfg_i,
  input  drxc_pkg::drxc_cmd_t    cmd_i,
  output drxc_pkg::drxc_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output drxc_pkg::drxc_out_t    out_data_o
);
  import drxc_pkg::*;

  // cycle length, zero acts as one
  function automatic logic [SLOT_BITS-1:0] cyc(input logic [SLOT_BITS-1:0] c);
    return (c == '0) ? SLOT_BITS'(1) : c;
  endfunction

  // one run of a timer
  function automatic drxc_tmr_t tm_run(input drxc_tmr_t t);
    drxc_tmr_t r;
    r = t;
    if (t.act) begin
      if (t.dly != '0) begin
        r.dly = t.dly - SLOT_BITS'(1);
      end else if (t.cnt != TMR_EXPIRED) begin
        r.cnt = t.cnt - TIMER_BITS'(1);
      end
      if (r.cnt == TMR_EXPIRED) begin
        r.act = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic drxc_tmr_t tm_start(input logic [TIMER_BITS-1:0] len,
                                         input logic [SLOT_BITS-1:0]  d);
    drxc_tmr_t r;
    r.act = 1'b1;
    r.cnt = len - TIMER_BITS'(1);
    r.dly = d;
    return r;
  endfunction

  function automatic drxc_tmr_t tm_clear(input logic [TIMER_BITS-1:0] len);
    drxc_tmr_t r;
    r.act = 1'b0;
    r.cnt = len;
    r.dly = '0;
    return r;
  endfunction

  function automatic logic tm_on(input drxc_tmr_t t);
    return t.act && (t.dly == '0);
  endfunction

  logic [SLOT_BITS-1:0]  cl, cs;
  logic [TIMER_BITS-1:0] on_len, inact_len, short_len;

  // captured word and remainders
  logic [SLOT_BITS-1:0] slot_q;
  logic                 pdcch_q, restart_q;
  logic [SLOT_BITS-1:0] loff_q, rem_l_q, rem_s_q, soff_new_q;

  // slot state
  drxc_tmr_t            on_q, in_q, sh_q;
  logic                 cs_q, awake_q;
  logic [SLOT_BITS-1:0] soff_q;

  // result register
  drxc_out_t out_q;
  logic      out_valid_q;

  // divider interface
  logic [SLOT_BITS-1:0] div_a, div_d, div_rem;
  logic                 div_done;

  // step results
  drxc_tmr_t            on_s1, sh_s1, on_s2, in_s2, sh_s2;
  logic                 cs_s1, aw_s1, cs_s2;
  logic [SLOT_BITS-1:0] soff_s1;
  drxc_out_t            res_s2;

  assign cl        = cyc(cfg_i.long_cycle);
  assign cs        = cyc(cfg_i.short_cycle);
  assign on_len    = TIMER_BITS'(cfg_i.on_duration_len);
  assign inact_len = TIMER_BITS'(cfg_i.inactivity_len);
  assign short_len = TIMER_BITS'(cfg_i.short_timer_len);

  // operand select for the remainder jobs
  always_comb begin
    case (cmd_i.op)
      OP_LOFF: begin
        div_a = cfg_i.long_offset;
        div_d = cl;
      end
      OP_SLOT_LONG: begin
        div_a = slot_q;
        div_d = cl;
      end
      OP_SLOT_SHORT: begin
        div_a = slot_q;
        div_d = cs;
      end
      OP_LOFF_SHORT: begin
        div_a = loff_q;
        div_d = cs;
      end
      default: begin
        div_a = slot_q;
        div_d = cl;
      end
    endcase
  end

  drxc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // step one: restart setup, short and on-duration timers, cycle starts
  always_comb begin
    on_s1   = on_q;
    sh_s1   = sh_q;
    cs_s1   = cs_q;
    soff_s1 = soff_q;
    aw_s1   = awake_q;
    if (restart_q) begin
      soff_s1 = soff_new_q;
      cs_s1   = 1'b0;
      on_s1   = tm_start(on_len, loff_q);
    end
    if (cfg_i.drx_enable) begin
      sh_s1 = tm_run(sh_s1);
      on_s1 = tm_run(on_s1);
      if (!cs_s1 || (sh_s1.cnt == TMR_EXPIRED)) begin
        if (cs_s1) begin
          cs_s1 = 1'b0;
          sh_s1 = tm_clear(short_len);
        end
        if (!tm_on(on_s1) && (rem_l_q == loff_q)) begin
          on_s1 = tm_start(on_len, '0);
        end
      end else if (!tm_on(on_s1) && (rem_s_q == soff_s1)) begin
        on_s1 = tm_start(on_len, '0);
      end
      aw_s1 = tm_on(on_s1) || tm_on(in_q);
    end else begin
      aw_s1 = 1'b1;
    end
  end

  // step two: inactivity timer and its expiry, and the result word
  always_comb begin
    on_s2 = on_q;
    in_s2 = in_q;
    sh_s2 = sh_q;
    cs_s2 = cs_q;
    if (cfg_i.drx_enable && awake_q) begin
      if (in_q.act) begin
        in_s2 = tm_run(in_q);
        if (pdcch_q) begin
          in_s2 = tm_start(inact_len, '0);
        end else if (in_s2.cnt == TMR_EXPIRED) begin
          if (cfg_i.short_enable) begin
            sh_s2 = tm_start(short_len, '0);
            cs_s2 = 1'b1;
          end else begin
            on_s2 = tm_start(on_len, loff_q);
            cs_s2 = 1'b0;
          end
        end
      end else if (pdcch_q) begin
        in_s2 = tm_start(inact_len, '0);
      end
    end
    res_s2.awake               = awake_q;
    res_s2.short_mode          = cs_s2;
    res_s2.on_duration_running = tm_on(on_s2);
    res_s2.inactivity_running  = tm_on(in_s2);
  end

  // status to the sequencer
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.restart  = restart_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // timer and mode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q        <= tm_clear(TIMER_BITS'(CFG_RST_ON_DUR_LEN));
      in_q        <= tm_clear(TIMER_BITS'(CFG_RST_INACT_LEN));
      sh_q        <= tm_clear(TIMER_BITS'(CFG_RST_SHORT_TMR));
      cs_q        <= 1'b0;
      awake_q     <= 1'b1;
      soff_q      <= RST_SHORT_OFFSET;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.step1) begin
        on_q    <= on_s1;
        sh_q    <= sh_s1;
        cs_q    <= cs_s1;
        soff_q  <= soff_s1;
        awake_q <= aw_s1;
      end else if (cmd_i.step2) begin
        on_q <= on_s2;
        in_q <= in_s2;
        sh_q <= sh_s2;
        cs_q <= cs_s2;
      end
      if (cmd_i.step2) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // captured word, remainders and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      slot_q    <= in_data_i.slot_number;
      pdcch_q   <= in_data_i.new_pdcch;
      restart_q <= in_data_i.restart;
    end
    if (cmd_i.rem_load) begin
      case (cmd_i.op)
        OP_LOFF:       loff_q     <= div_rem;
        OP_SLOT_LONG:  rem_l_q    <= div_rem;
        OP_SLOT_SHORT: rem_s_q    <= div_rem;
        OP_LOFF_SHORT: soff_new_q <= div_rem;
        default:       loff_q     <= div_rem;
      endcase
    end
    if (cmd_i.step2) begin
      out_q <= res_s2;
    end
  end

endmodule

@@ rtl/drxc_checker.sv @@
// ----------------------------------------------------------------------------
// drxc_checker
// Port-level checks of the DRX controller, attached by bind.
// ----------------------------------------------------------------------------
module drxc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input drxc_pkg::drxc_out_t             out_data_o
);
  import drxc_pkg::*;

  // a stalled result holds its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again right after an accept");

  // remainder jobs keep the block busy for a while
  a_min_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##20 !in_ready_o)
    else $error("slot word finished too early");

  // a running timer implies the receiver is awake
  a_running_awake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.on_duration_running || out_data_o.inactivity_running)
      |-> out_data_o.awake)
    else $error("timer running while asleep");

endmodule

bind drx_sleep_cycle_controller drxc_checker u_drxc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ tb/drx_sleep_cycle_controller_test.sv @@
// ----------------------------------------------------------------------------
// drx_sleep_cycle_controller_test
// Drives slot words through the DRX controller and predicts every result
// word from a cycle-free model of the timers and cycle mode. Configuration
// is reprogrammed between phases while the block is idle. Both handshakes
// idle and stall at random, with some phases running at full rate.
// ----------------------------------------------------------------------------
module drx_sleep_cycle_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import drxc_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int PHASE_WORDS = 48;
  localparam int NUM_PHASES  = 12;
  localparam int DRAIN_WAIT  = 60;

  // slot timing predictor and expected result store
  class drx_slot_scoreboard;
    drxc_cfg_t            regs;
    drxc_tmr_t            on_tmr;
    drxc_tmr_t            inact_tmr;
    drxc_tmr_t            short_tmr;
    logic                 short_cycle_mode;
    logic                 rx_awake;
    logic [SLOT_BITS-1:0] short_phase;
    drxc_out_t            expected_q[$];
    int                   errors;

    function new();
      regs                 = '0;
      regs.long_cycle      = CFG_RST_LONG_CYCLE;
      regs.short_cycle     = CFG_RST_SHORT_CYCLE;
      regs.long_offset     = CFG_RST_LONG_OFFSET;
      regs.on_duration_len = CFG_RST_ON_DUR_LEN;
      regs.inactivity_len  = CFG_RST_INACT_LEN;
      regs.short_timer_len = CFG_RST_SHORT_TMR;
      on_tmr               = timer_idle(SLOT_BITS'(regs.on_duration_len));
      inact_tmr            = timer_idle(SLOT_BITS'(regs.inactivity_len));
      short_tmr            = timer_idle(regs.short_timer_len);
      short_cycle_mode     = 1'b0;
      rx_awake             = 1'b1;
      short_phase          = long_phase() % cyc_len(regs.short_cycle);
      errors               = 0;
    endfunction

    // a cycle length of zero behaves as one
    function logic [SLOT_BITS-1:0] cyc_len(logic [SLOT_BITS-1:0] c);
      return (c == '0) ? SLOT_BITS'(1) : c;
    endfunction

    function logic [SLOT_BITS-1:0] long_phase();
      return regs.long_offset % cyc_len(regs.long_cycle);
    endfunction

    function drxc_tmr_t timer_idle(logic [SLOT_BITS-1:0] len);
      drxc_tmr_t t;
      t.act = 1'b0;
      t.cnt = TIMER_BITS'(len);
      t.dly = '0;
      return t;
    endfunction

    // load length minus one, wrapping a zero length to the expired count
    function drxc_tmr_t timer_start(logic [SLOT_BITS-1:0] len, logic [SLOT_BITS-1:0] dly);
      drxc_tmr_t t;
      t.act = 1'b1;
      t.cnt = TIMER_BITS'(len) - TIMER_BITS'(1);
      t.dly = dly;
      return t;
    endfunction

    // delay first, then count down to the expired value
    function drxc_tmr_t timer_tick(drxc_tmr_t t);
      if (!t.act) return t;
      if (t.dly != '0) t.dly = t.dly - SLOT_BITS'(1);
      else if (t.cnt != TMR_EXPIRED) t.cnt = t.cnt - TIMER_BITS'(1);
      if (t.cnt == TMR_EXPIRED) t.act = 1'b0;
      return t;
    endfunction

    function logic running(drxc_tmr_t t);
      return t.act && (t.dly == '0);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_DRX_ENABLE:   regs.drx_enable      = d[0];
        CFG_SHORT_ENABLE: regs.short_enable    = d[0];
        CFG_LONG_CYCLE:   regs.long_cycle      = d;
        CFG_SHORT_CYCLE:  regs.short_cycle     = d;
        CFG_LONG_OFFSET:  regs.long_offset     = d;
        CFG_ON_DUR_LEN:   regs.on_duration_len = d[14:0];
        CFG_INACT_LEN:    regs.inactivity_len  = d[15:0];
        CFG_SHORT_TMR:    regs.short_timer_len = d;
        default: ;
      endcase
    endfunction

    // advance one slot and queue the result word it yields
    function void note_word(drxc_in_t w);
      logic [SLOT_BITS-1:0] loff;
      drxc_out_t            e;
      loff = long_phase();
      if (w.restart) begin
        short_phase      = loff % cyc_len(regs.short_cycle);
        short_cycle_mode = 1'b0;
        on_tmr           = timer_start(SLOT_BITS'(regs.on_duration_len), loff);
      end
      if (regs.drx_enable) begin
        short_tmr = timer_tick(short_tmr);
        on_tmr    = timer_tick(on_tmr);
        // long cycle, or short cycle that just ran out
        if (!short_cycle_mode || short_tmr.cnt == TMR_EXPIRED) begin
          if (short_cycle_mode) begin
            short_cycle_mode = 1'b0;
            short_tmr        = timer_idle(regs.short_timer_len);
          end
          if (!running(on_tmr) && w.slot_number % cyc_len(regs.long_cycle) == loff)
            on_tmr = timer_start(SLOT_BITS'(regs.on_duration_len), '0);
        end else if (!running(on_tmr) &&
                     w.slot_number % cyc_len(regs.short_cycle) == short_phase) begin
          on_tmr = timer_start(SLOT_BITS'(regs.on_duration_len), '0);
        end
        rx_awake = running(on_tmr) || running(inact_tmr);
        // inactivity handling only while awake
        if (rx_awake) begin
          if (inact_tmr.act) begin
            inact_tmr = timer_tick(inact_tmr);
            if (w.new_pdcch) begin
              inact_tmr = timer_start(SLOT_BITS'(regs.inactivity_len), '0);
            end else if (inact_tmr.cnt == TMR_EXPIRED) begin
              if (regs.short_enable) begin
                short_tmr        = timer_start(regs.short_timer_len, '0);
                short_cycle_mode = 1'b1;
              end else begin
                on_tmr           = timer_start(SLOT_BITS'(regs.on_duration_len), loff);
                short_cycle_mode = 1'b0;
              end
            end
          end else if (w.new_pdcch) begin
            inact_tmr = timer_start(SLOT_BITS'(regs.inactivity_len), '0);
          end
        end
      end else begin
        rx_awake = 1'b1;
      end
      e.awake               = rx_awake;
      e.short_mode          = short_cycle_mode;
      e.on_duration_running = running(on_tmr);
      e.inactivity_running  = running(inact_tmr);
      expected_q.push_back(e);
    endfunction

    task report(string what);
      $display("[%0t] error: %s", $time, what);
      errors++;
    endtask

    task check_word(drxc_out_t got);
      drxc_out_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result word %b with nothing expected", got));
        return;
      end
      e = expected_q.pop_front();
      if (got.awake !== e.awake)
        report($sformatf("awake got %b want %b", got.awake, e.awake));
      if (got.short_mode !== e.short_mode)
        report($sformatf("short_mode got %b want %b", got.short_mode, e.short_mode));
      if (got.on_duration_running !== e.on_duration_running)
        report($sformatf("on_duration_running got %b want %b",
                         got.on_duration_running, e.on_duration_running));
      if (got.inactivity_running !== e.inactivity_running)
        report($sformatf("inactivity_running got %b want %b",
                         got.inactivity_running, e.inactivity_running));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  drxc_in_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  drxc_out_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  drx_slot_scoreboard    slot_sb = new();
  logic [CFG_DATA_W-1:0] phase_regs [8];
  bit                    calm = 1'b0;
  int                    cycle_cnt = 0;

  drx_sleep_cycle_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one slot word; entered and left at a falling edge with valid high
  task send_word(drxc_in_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = w;
    do @(posedge clk_i); while (!in_ready_o);
    slot_sb.note_word(w);
    @(negedge clk_i);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      cfg_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    slot_sb.set_reg(idx, d);
    @(negedge clk_i);
  endtask

  task set_phase(logic drx, logic shrt, logic [17:0] lc, logic [17:0] sc, logic [17:0] lo,
                 logic [17:0] on_len, logic [17:0] in_len, logic [17:0] st_len);
    phase_regs[CFG_DRX_ENABLE]   = {17'd0, drx};
    phase_regs[CFG_SHORT_ENABLE] = {17'd0, shrt};
    phase_regs[CFG_LONG_CYCLE]   = lc;
    phase_regs[CFG_SHORT_CYCLE]  = sc;
    phase_regs[CFG_LONG_OFFSET]  = lo;
    phase_regs[CFG_ON_DUR_LEN]   = on_len;
    phase_regs[CFG_INACT_LEN]    = in_len;
    phase_regs[CFG_SHORT_TMR]    = st_len;
  endtask

  task program_regs();
    for (int i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), phase_regs[CFG_IDX_W'(i)]);
    cfg_valid_i = 1'b0;
  endtask

  // stop sending and wait until every result word is back
  task finish_phase();
    in_valid_i = 1'b0;
    while (slot_sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly consecutive slots, with jumps, restarts and control traffic
  task run_random(int n, logic [17:0] first_slot);
    drxc_in_t    w;
    logic [17:0] slot;
    int          pd_rate;
    slot    = first_slot;
    pd_rate = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) slot = 18'($urandom_range(0, 262143));
      else slot = slot + 18'(1);
      w.slot_number = slot;
      w.new_pdcch   = ($urandom_range(0, pd_rate) == 0);
      w.restart     = ($urandom_range(0, 29) == 0);
      send_word(w);
    end
  endtask

  // result side with random stalls
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      slot_sb.check_word(out_data_o);
      @(negedge clk_i);
    end
  end

  // reset, directed slots, then random phases
  initial begin
    drxc_in_t w;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset configuration, reception forced on
    w = '{slot_number: 18'd0, new_pdcch: 1'b1, restart: 1'b1};
    send_word(w);
    w = '{slot_number: 18'h3ffff, new_pdcch: 1'b0, restart: 1'b0};
    send_word(w);
    finish_phase();

    // short timers, offset beyond the long cycle
    set_phase(1'b1, 1'b1, 18'd8, 18'd3, 18'd10, 18'd2, 18'd2, 18'd4);
    program_regs();
    for (int s = 0; s < 20; s++) begin
      w.slot_number = 18'(s);
      w.new_pdcch   = (s == 3 || s == 10 || s == 11);
      w.restart     = (s == 0);
      send_word(w);
    end
    w = '{slot_number: 18'd163839, new_pdcch: 1'b1, restart: 1'b0};
    send_word(w);
    w = '{slot_number: 18'h3ffff, new_pdcch: 1'b0, restart: 1'b0};
    send_word(w);
    w = '{slot_number: 18'h3fffe, new_pdcch: 1'b1, restart: 1'b1};
    send_word(w);
    finish_phase();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_phase(1'b1, 1'b1, 18'd20, 18'd5, 18'd7, 18'd3, 18'd4, 18'd10);
        // short cycle disabled, possibly while still in short mode
        1: set_phase(1'b1, 1'b0, 18'd16, 18'd4, 18'd35, 18'd2, 18'd3, 18'd6);
        // zero cycles and zero timer lengths
        2: set_phase(1'b1, 1'b1, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0);
        // every register bit set but the short cycle
        3: set_phase(1'b1, 1'b1, 18'h3ffff, 18'd163840, 18'h3ffff, 18'd32767,
                     18'd65535, 18'h3ffff);
        4: set_phase(1'b1, 1'b1, 18'd163840, 18'd1, 18'd163839, 18'd25600,
                     18'd40960, 18'd163840);
        5: set_phase(1'b0, 1'b1, 18'd12, 18'd3, 18'd5, 18'd2, 18'd2, 18'd5);
        default:
          set_phase($urandom_range(0, 5) != 0, 1'($urandom_range(0, 1)),
                    18'($urandom_range(1, 24)), 18'($urandom_range(1, 8)),
                    18'($urandom_range(0, 40)), 18'($urandom_range(0, 6)),
                    18'($urandom_range(0, 6)), 18'($urandom_range(0, 12)));
      endcase
      calm = ($urandom_range(0, 3) == 0);
      program_regs();
      run_random(PHASE_WORDS, phase_regs[CFG_LONG_OFFSET] - 18'($urandom_range(0, 30)));
      finish_phase();
    end

    // late extra words show up as unexpected results
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (slot_sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/drxc_pkg.sv
rtl/drxc_cfg.sv
rtl/drxc_ctrl.sv
rtl/drxc_div.sv
rtl/drxc_dp.sv
rtl/drx_sleep_cycle_controller.sv
rtl/drxc_checker.sv
tb/drx_sleep_cycle_controller_test.sv
